FILE: rtl/software_timer_table_macros.svh
// Assertion macros for the software timer table.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
// Shared types, action codes and the microcode ROM of the software timer table.
// No dependencies.
package stt_pkg;

    localparam int ACTION_W   = 3;
    localparam int ID_W       = 4;
    localparam int INTERVAL_W = 31;
    localparam int COUNT_W    = 5;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [ID_W-1:0]       timer_id;
        logic [INTERVAL_W-1:0] interval_ms;
    } req_t;

    typedef struct packed {
        logic               fired;
        logic [ID_W-1:0]    fired_id;
        logic [COUNT_W-1:0] armed_count;
    } rsp_t;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INIT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP   = 3'd4;

    // Datapath operations, one per control word
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE        = 4'd0;
    localparam logic [OP_W-1:0] OP_NOW_INC     = 4'd1;
    localparam logic [OP_W-1:0] OP_READ_ID     = 4'd2;
    localparam logic [OP_W-1:0] OP_WRITE_INIT  = 4'd3;
    localparam logic [OP_W-1:0] OP_WRITE_START = 4'd4;
    localparam logic [OP_W-1:0] OP_GRAB        = 4'd5;
    localparam logic [OP_W-1:0] OP_SHIFT       = 4'd6;
    localparam logic [OP_W-1:0] OP_RESPOND     = 4'd7;
    localparam logic [OP_W-1:0] OP_SCAN_INIT   = 4'd8;
    localparam logic [OP_W-1:0] OP_POP_STEP    = 4'd9;
    localparam logic [OP_W-1:0] OP_NOP         = 4'd10;
    localparam logic [OP_W-1:0] OP_TAKE        = 4'd11;

    // Jump conditions; a false condition falls through to the next step
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NONE      = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] COND_ID_BAD    = 3'd2;
    localparam logic [COND_W-1:0] COND_ID_IDLE   = 3'd3;
    localparam logic [COND_W-1:0] COND_MORE      = 3'd4;
    localparam logic [COND_W-1:0] COND_NOT_FOUND = 3'd5;

    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] UPC_TICK      = 4'd1;
    localparam logic [UPC_W-1:0] UPC_INIT_RD   = 4'd2;
    localparam logic [UPC_W-1:0] UPC_INIT_WR   = 4'd3;
    localparam logic [UPC_W-1:0] UPC_START_RD  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_START_WR  = 4'd5;
    localparam logic [UPC_W-1:0] UPC_STOP_RD   = 4'd6;
    localparam logic [UPC_W-1:0] UPC_GRAB      = 4'd7;
    localparam logic [UPC_W-1:0] UPC_SHIFT     = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DONE      = 4'd9;
    localparam logic [UPC_W-1:0] UPC_POP_INIT  = 4'd10;
    localparam logic [UPC_W-1:0] UPC_POP_SCAN  = 4'd11;
    localparam logic [UPC_W-1:0] UPC_POP_CHECK = 4'd12;
    localparam logic [UPC_W-1:0] UPC_TAKE      = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t word;
        unique case (addr)
            UPC_TICK:      word = '{OP_NOW_INC,     COND_ALWAYS,    UPC_DONE};
            UPC_INIT_RD:   word = '{OP_READ_ID,     COND_ID_BAD,    UPC_DONE};
            UPC_INIT_WR:   word = '{OP_WRITE_INIT,  COND_ALWAYS,    UPC_DONE};
            UPC_START_RD:  word = '{OP_READ_ID,     COND_ID_BAD,    UPC_DONE};
            UPC_START_WR:  word = '{OP_WRITE_START, COND_ALWAYS,    UPC_DONE};
            UPC_STOP_RD:   word = '{OP_READ_ID,     COND_ID_IDLE,   UPC_DONE};
            UPC_GRAB:      word = '{OP_GRAB,        COND_NONE,      UPC_IDLE};
            UPC_SHIFT:     word = '{OP_SHIFT,       COND_MORE,      UPC_SHIFT};
            UPC_DONE:      word = '{OP_RESPOND,     COND_NONE,      UPC_IDLE};
            UPC_POP_INIT:  word = '{OP_SCAN_INIT,   COND_NONE,      UPC_IDLE};
            UPC_POP_SCAN:  word = '{OP_POP_STEP,    COND_MORE,      UPC_POP_SCAN};
            UPC_POP_CHECK: word = '{OP_NOP,         COND_NOT_FOUND, UPC_DONE};
            UPC_TAKE:      word = '{OP_TAKE,        COND_ALWAYS,    UPC_SHIFT};
            default:       word = '{OP_IDLE,        COND_NONE,      UPC_IDLE};
        endcase
        return word;
    endfunction

    function automatic logic [UPC_W-1:0] entry_addr(input logic [ACTION_W-1:0] action);
        logic [UPC_W-1:0] addr;
        unique case (action)
            ACT_TICK:  addr = UPC_TICK;
            ACT_INIT:  addr = UPC_INIT_RD;
            ACT_START: addr = UPC_START_RD;
            ACT_STOP:  addr = UPC_STOP_RD;
            ACT_POP:   addr = UPC_POP_INIT;
            default:   addr = UPC_DONE;
        endcase
        return addr;
    endfunction

endpackage

FILE: rtl/software_timer_table.sv
// Software timer table: one-shot timers kept in arming order; needs stt_pkg, stt_ram
// and software_timer_table_macros.svh. One request at a time, one response each.
// Tick bumps the clock; init/start read, then write the slot; stop (of an armed slot) and
// pop scan the slot RAM, one slot per cycle, and pop scans again if a timer expired.
// Reset (rst_n, async low): clock zero, all slots disarmed; no clearing pass is needed.
module software_timer_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  stt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output stt_pkg::rsp_t rsp
);

    `include "software_timer_table_macros.svh"

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENT_W   = stt_pkg::INTERVAL_W + TIME_BITS + IDX_W;
    localparam int CMP_W   = (TIME_BITS > stt_pkg::INTERVAL_W) ? TIME_BITS
                                                                : stt_pkg::INTERVAL_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Sequencer state
    logic [stt_pkg::UPC_W-1:0] upc_reg, upc_next;
    stt_pkg::ctrl_t            ctrl;
    logic                      jump;

    // Request and architectural state
    stt_pkg::req_t        item_reg, item_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [SLOTS-1:0]     armed_reg, armed_next;
    logic [SLOTS-1:0]     written_reg, written_next;
    logic [CNT_W-1:0]     total_reg, total_next;

    // Scan and removal working registers
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic [IDX_W-1:0] vrank_reg, vrank_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] best_rank_reg, best_rank_next;
    logic             fired_reg, fired_next;
    logic [IDX_W-1:0] rd_addr_reg;

    // Response register
    logic          rsp_valid_reg, rsp_valid_next;
    stt_pkg::rsp_t rsp_reg, rsp_next;

    // Slot RAM: {interval, start time, rank}
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // Decoded read data; an entry never written reads as zero
    logic [stt_pkg::INTERVAL_W-1:0] ent_interval;
    logic [TIME_BITS-1:0]           ent_start;
    logic [IDX_W-1:0]               ent_rank;
    logic [TIME_BITS-1:0]           elapsed;
    logic                           expired;

    logic             id_ok;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] idx_step;
    logic             done_ok;

    stt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ctrl      = stt_pkg::ucode_rom(upc_reg);
    assign req_ready = (upc_reg == stt_pkg::UPC_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Slot numbers at or above SLOTS address nothing
    assign id_ok = (int'(item_reg.timer_id) < SLOTS);
    assign slot  = IDX_W'(item_reg.timer_id);

    assign {ent_interval, ent_start, ent_rank} = written_reg[rd_addr_reg] ? ram_rdata
                                                                          : '0;

    // Elapsed time wraps with the clock; expiry is strictly past the interval
    assign elapsed = TIME_BITS'(now_reg - ent_start);
    assign expired = CMP_W'(elapsed) > CMP_W'(ent_interval);

    // Next scan slot; on the last slot park the read address at zero
    assign idx_step = (idx_reg == LAST_IDX) ? '0 : IDX_W'(idx_reg + 1'b1);

    // The result may leave once the response register is free or draining
    assign done_ok = !rsp_valid_reg || rsp_ready;

    // Jump condition of the current control word
    always_comb
    begin
        unique case (ctrl.cond)
            stt_pkg::COND_ALWAYS:    jump = 1'b1;
            stt_pkg::COND_ID_BAD:    jump = !id_ok;
            stt_pkg::COND_ID_IDLE:   jump = !(id_ok && armed_reg[slot]);
            stt_pkg::COND_MORE:      jump = (idx_reg != LAST_IDX);
            stt_pkg::COND_NOT_FOUND: jump = !found_reg;
            default:                 jump = 1'b0;
        endcase
    end

    // Datapath: one operation per step, chosen by the control word
    always_comb
    begin
        upc_next       = jump ? ctrl.target : stt_pkg::UPC_W'(upc_reg + 1'b1);
        item_next      = item_reg;
        now_next       = now_reg;
        armed_next     = armed_reg;
        written_next   = written_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        victim_next    = victim_reg;
        vrank_next     = vrank_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_rank_next = best_rank_reg;
        fired_next     = fired_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = slot;
        ram_wdata      = {ent_interval, now_reg, ent_rank};
        ram_raddr      = '0;

        unique case (ctrl.op)
            stt_pkg::OP_IDLE:
            begin
                // Wait for a request, then dispatch on its action
                if (req_valid)
                begin
                    item_next  = req;
                    fired_next = 1'b0;
                    upc_next   = stt_pkg::entry_addr(req.action);
                end
                else
                begin
                    upc_next = stt_pkg::UPC_IDLE;
                end
            end
            stt_pkg::OP_NOW_INC:
            begin
                now_next = TIME_BITS'(now_reg + 1'b1);
            end
            stt_pkg::OP_READ_ID:
            begin
                ram_raddr = slot;
            end
            stt_pkg::OP_WRITE_INIT:
            begin
                // New interval, restart; armed flag and order stay
                ram_we             = 1'b1;
                ram_wdata          = {item_reg.interval_ms, now_reg, ent_rank};
                written_next[slot] = 1'b1;
            end
            stt_pkg::OP_WRITE_START:
            begin
                // Restart in place, or arm and append last
                ram_we             = 1'b1;
                written_next[slot] = 1'b1;
                if (armed_reg[slot])
                begin
                    ram_wdata = {ent_interval, now_reg, ent_rank};
                end
                else
                begin
                    ram_wdata        = {ent_interval, now_reg, IDX_W'(total_reg)};
                    armed_next[slot] = 1'b1;
                    total_next       = CNT_W'(total_reg + 1'b1);
                end
            end
            stt_pkg::OP_GRAB:
            begin
                // Disarm the stopped slot and start the rank shift at slot zero
                victim_next      = slot;
                vrank_next       = ent_rank;
                armed_next[slot] = 1'b0;
                total_next       = CNT_W'(total_reg - 1'b1);
                idx_next         = '0;
            end
            stt_pkg::OP_TAKE:
            begin
                // Disarm the popped slot and start the rank shift at slot zero
                victim_next          = best_reg;
                vrank_next           = best_rank_reg;
                armed_next[best_reg] = 1'b0;
                total_next           = CNT_W'(total_reg - 1'b1);
                fired_next           = 1'b1;
                idx_next             = '0;
            end
            stt_pkg::OP_SHIFT:
            begin
                // Move every later armed slot up one place
                ram_waddr = idx_reg;
                ram_wdata = {ent_interval, ent_start, IDX_W'(ent_rank - 1'b1)};
                ram_we    = armed_reg[idx_reg] && (ent_rank > vrank_reg);
                ram_raddr = idx_step;
                idx_next  = idx_step;
            end
            stt_pkg::OP_SCAN_INIT:
            begin
                found_next = 1'b0;
                idx_next   = '0;
            end
            stt_pkg::OP_POP_STEP:
            begin
                // Keep the earliest-armed expired slot seen so far
                if (armed_reg[idx_reg] && expired
                    && (!found_reg || (ent_rank < best_rank_reg)))
                begin
                    found_next     = 1'b1;
                    best_next      = idx_reg;
                    best_rank_next = ent_rank;
                end
                ram_raddr = idx_step;
                idx_next  = idx_step;
            end
            stt_pkg::OP_RESPOND:
            begin
                // Hold here until the response register can take the result
                if (done_ok)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.fired       = fired_reg;
                    rsp_next.fired_id    = fired_reg ? stt_pkg::ID_W'(victim_reg) : '0;
                    rsp_next.armed_count = stt_pkg::COUNT_W'(total_reg);
                    upc_next             = stt_pkg::UPC_IDLE;
                end
                else
                begin
                    upc_next = upc_reg;
                end
            end
            default:
            begin
                // Plain step: nothing but the sequencer advances
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= stt_pkg::UPC_IDLE;
            now_reg       <= '0;
            armed_reg     <= '0;
            written_reg   <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            fired_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            now_reg       <= now_next;
            armed_reg     <= armed_next;
            written_reg   <= written_next;
            total_reg     <= total_next;
            found_reg     <= found_next;
            fired_reg     <= fired_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        victim_reg    <= victim_next;
        vrank_reg     <= vrank_next;
        best_reg      <= best_next;
        best_rank_reg <= best_rank_next;
        rsp_reg       <= rsp_next;
        rd_addr_reg   <= ram_raddr;
    end

    // Armed count always matches the armed flags
    `STT_ASSERT_NOW(a_total_matches_flags, 1'b1, total_reg == CNT_W'($countones(armed_reg)), "armed count out of step with armed flags")

    // A pop only takes a slot that the scan found armed
    `STT_ASSERT_NOW(a_take_armed, ctrl.op == stt_pkg::OP_TAKE, found_reg && armed_reg[best_reg], "pop takes a slot that is not armed")

    // The removed slot is disarmed in the next cycle
    `STT_ASSERT_NEXT(a_victim_disarmed, (ctrl.op == stt_pkg::OP_GRAB) || (ctrl.op == stt_pkg::OP_TAKE), !armed_reg[victim_reg], "removed slot still armed")

    // The rank shift never rewrites the removed slot
    `STT_ASSERT_NOW(a_shift_skips_victim, (ctrl.op == stt_pkg::OP_SHIFT) && ram_we, ram_waddr != victim_reg, "rank shift writes the removed slot")

    // A response without a fired timer carries slot zero
    `STT_ASSERT_NOW(a_idle_id_zero, rsp_valid && !rsp.fired, rsp.fired_id == '0, "fired_id set without a fired timer")

endmodule

FILE: rtl/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
